// File: rtl/nsr_pkg.sv
`default_nettype none

package nsr_pkg;

    // Iteration cap
    localparam int MAX_PASSES = 32;
    localparam int PASS_W     = $clog2(MAX_PASSES + 1);

    // Field widths
    localparam int VAL_W   = 32;             // Q16.16
    localparam int LIMIT_W = 18;             // Q2.16
    localparam int FRAC_W  = 16;
    localparam int DVD_W   = VAL_W + FRAC_W; // x << 16
    localparam int BIT_W   = $clog2(DVD_W);
    localparam int SQ_W    = 2 * VAL_W;
    localparam int BOUND_W = LIMIT_W + VAL_W;

    localparam int PASSES_W = 6;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;            // root, passes, zero pad

    localparam logic [VAL_W-1:0] ONE_Q16 = VAL_W'(32'h0001_0000);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(66191);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUND,
        ST_DIV,
        ST_UPDATE,
        ST_SQUARE,
        ST_CHECK,
        ST_DONE
    } nsr_state_t;

endpackage

`default_nettype wire

// File: rtl/newton_square_root.sv
`default_nettype none

// Newton-Raphson square root, unsigned Q16.16 in and out, one transaction at a time.
// A zero input skips the passes; otherwise P passes are made, P = 1..MAX_PASSES.
// Each pass is a restoring divide (one quotient bit per cycle) in the shared
// divider, one update, one 32x32 square and one compare. Input ready only when idle.
// A new input is taken only once the last result is loaded, which waits while m_tready holds off.
// Reset (aresetn, synchronous, active low) clears the sequencer and output valid and
// loads ratio_limit with its default of about 1.01 (Q2.16).

module newton_square_root (
    input  wire                          aclk,
    input  wire                          aresetn,

    // Input stream
    input  wire                          s_tvalid,
    output logic                         s_tready,
    input  wire  [nsr_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] input_value

    // Result stream
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [nsr_pkg::M_DATA_W-1:0] m_tdata,   // [31:0] root, [37:32] passes, [39:38] zero
    output logic [0:0]                   m_tuser,   // [0] hit_limit

    // Configuration write: ratio_limit
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [nsr_pkg::LIMIT_W-1:0]  cfg_data
);

    import nsr_pkg::*;

    nsr_state_t state_reg, state_next;

    logic [LIMIT_W-1:0] limit_reg;

    // Operands and loop state
    logic [VAL_W-1:0]   x_reg,     x_next;
    logic [VAL_W-1:0]   guess_reg, guess_next;
    logic [PASS_W-1:0]  pass_reg,  pass_next;
    logic [BOUND_W-1:0] bound_reg, bound_next;
    logic [SQ_W-1:0]    sq_reg,    sq_next;

    // Shared restoring divider: dividend shifts out as quotient shifts in
    logic [DVD_W-1:0]   dvd_reg,   dvd_next;
    logic [VAL_W-1:0]   rem_reg,   rem_next;
    logic [BIT_W-1:0]   bit_reg,   bit_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [VAL_W-1:0]   root_reg,  root_next;
    logic [PASS_W-1:0]  opass_reg, opass_next;
    logic               hit_reg,   hit_next;
    logic               fin_hit_reg, fin_hit_next;

    // Datapath helpers
    logic [VAL_W-1:0]   divisor;
    logic [VAL_W:0]     trial;
    logic [VAL_W+1:0]   diff;
    logic               q_bit;
    logic [DVD_W:0]     sum;
    logic [DVD_W-1:0]   half;
    logic [VAL_W-1:0]   new_guess;
    logic               converged;
    logic               at_cap;
    logic               out_free;
    logic [PASS_W+PASSES_W-1:0] pass_ext;

    // Zero guess never occurs for nonzero x; kept as 1 to avoid a zero divisor
    assign divisor = (guess_reg == '0) ? VAL_W'(1) : guess_reg;
    assign trial   = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff    = {1'b0, trial} - {2'b00, divisor};
    assign q_bit   = ~diff[VAL_W+1];

    // (q + g) / 2, saturated to 32 bits
    assign sum       = {1'b0, dvd_reg} + {{(DVD_W-VAL_W+1){1'b0}}, guess_reg};
    assign half      = sum[DVD_W:1];
    assign new_guess = (half[DVD_W-1:VAL_W] != '0) ? '1 : half[VAL_W-1:0];

    assign converged = sq_reg < {{(SQ_W-BOUND_W){1'b0}}, bound_reg};
    assign at_cap    = pass_reg >= PASS_W'(MAX_PASSES);
    assign out_free  = ~out_valid_reg | m_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign pass_ext  = {{PASSES_W{1'b0}}, opass_reg};
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, pass_ext[PASSES_W-1:0], root_reg};
    assign m_tuser   = hit_reg;

    always_comb begin
        state_next     = state_reg;
        x_next         = x_reg;
        guess_next     = guess_reg;
        pass_next      = pass_reg;
        bound_next     = bound_reg;
        sq_next        = sq_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        fin_hit_next   = fin_hit_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        root_next      = root_reg;
        opass_next     = opass_reg;
        hit_next       = hit_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    x_next       = s_tdata[VAL_W-1:0];
                    guess_next   = ONE_Q16;
                    pass_next    = '0;
                    fin_hit_next = 1'b0;
                    if (s_tdata[VAL_W-1:0] == '0) begin
                        guess_next = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_BOUND;
                    end
                end
            end
            ST_BOUND: begin
                // limit * x, at scale 2^-32 like g*g
                bound_next = BOUND_W'(limit_reg) * BOUND_W'(x_reg);
                dvd_next   = {x_reg, {FRAC_W{1'b0}}};
                rem_next   = '0;
                bit_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next = q_bit ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], q_bit};
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_W'(DVD_W - 1)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                guess_next = new_guess;
                pass_next  = pass_reg + PASS_W'(1);
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                sq_next    = SQ_W'(guess_reg) * SQ_W'(guess_reg);
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (converged) begin
                    state_next = ST_DONE;
                end else if (at_cap) begin
                    fin_hit_next = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    dvd_next   = {x_reg, {FRAC_W{1'b0}}};
                    rem_next   = '0;
                    bit_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DONE: begin
                // wait until the output register is free
                if (out_free) begin
                    out_valid_next = 1'b1;
                    root_next      = guess_reg;
                    opass_next     = pass_reg;
                    hit_next       = fin_hit_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        guess_reg   <= guess_next;
        pass_reg    <= pass_next;
        bound_reg   <= bound_next;
        sq_reg      <= sq_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        bit_reg     <= bit_next;
        fin_hit_reg <= fin_hit_next;
        root_reg    <= root_next;
        opass_reg   <= opass_next;
        hit_reg     <= hit_next;
    end

endmodule

`default_nettype wire
